// ===== sv/ssl_pkg.sv =====
`default_nettype none

package ssl_pkg;

    localparam int COUNT_BITS   = 16;
    localparam int SUM_BITS     = 40;
    localparam int NUM_CH       = 7;
    localparam int NUM_SUM      = 4;
    localparam int CH_BITS      = 3;
    localparam int VAL_BITS     = 16;
    localparam int OUT_BITS     = 15;
    localparam int TOTAL_BITS   = 16;
    localparam int VOTE_BITS    = 16;
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);
    localparam int CMP_BITS     = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;

    localparam int S_TDATA_BITS = 96;
    localparam int M_TDATA_BITS = 64;

    localparam logic [CH_BITS-1:0] LAST_CH = CH_BITS'(NUM_CH - 1);

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_SAMPLE = 2'd1,
        FUNC_REPORT = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        COLOR_NONE  = 2'd0,
        COLOR_RED   = 2'd1,
        COLOR_GREEN = 2'd2,
        COLOR_BLUE  = 2'd3
    } t_color;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SAMPLE,
        ST_REP_START,
        ST_REP_DIV,
        ST_REP_EMIT
    } t_state;

    // sample word, temperature in the lowest bits
    typedef struct packed {
        logic signed [14:0] accel_z;
        logic signed [14:0] accel_y;
        logic signed [14:0] accel_x;
        logic [1:0]         color_code;
        logic [9:0]         moisture;
        logic [9:0]         light;
        logic [9:0]         humidity;
        logic signed [11:0] temperature;
    } t_sample;

    localparam int SAMPLE_BITS = $bits(t_sample);

    typedef struct packed {
        logic                       start;
        logic signed [SUM_BITS-1:0] dividend;
        logic [COUNT_BITS-1:0]      divisor;
    } t_div_req;

    typedef struct packed {
        logic                       done;
        logic signed [SUM_BITS-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic s_ready;
        logic clear;
        logic step;
        logic div_start;
        logic emit;
    } t_ctl;

    function automatic logic signed [VAL_BITS-1:0] low_sentinel(input logic [CH_BITS-1:0] ch);
        logic signed [VAL_BITS-1:0] v;
        unique case (ch)
            3'd0:                v = -16'sd600;
            3'd1, 3'd2, 3'd3:    v = 16'sd0;
            default:             v = -16'sd9900;
        endcase
        return v;
    endfunction

    function automatic logic signed [VAL_BITS-1:0] high_sentinel(input logic [CH_BITS-1:0] ch);
        logic signed [VAL_BITS-1:0] v;
        unique case (ch)
            3'd0:                v = 16'sd2000;
            3'd1, 3'd2, 3'd3:    v = 16'sd1000;
            default:             v = 16'sd9900;
        endcase
        return v;
    endfunction

    function automatic logic signed [VAL_BITS-1:0] chan_val(input t_sample s,
                                                           input logic [CH_BITS-1:0] ch);
        logic signed [VAL_BITS-1:0] v;
        unique case (ch)
            3'd0:    v = VAL_BITS'(s.temperature);
            3'd1:    v = {6'd0, s.humidity};
            3'd2:    v = {6'd0, s.light};
            3'd3:    v = {6'd0, s.moisture};
            3'd4:    v = VAL_BITS'(s.accel_x);
            3'd5:    v = VAL_BITS'(s.accel_y);
            default: v = VAL_BITS'(s.accel_z);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/ssl_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle, truncates toward zero.
module ssl_divider (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  ssl_pkg::t_div_req   i_req,
    output ssl_pkg::t_div_rsp   o_rsp
);

    localparam int SB = ssl_pkg::SUM_BITS;
    localparam int CB = ssl_pkg::COUNT_BITS;

    logic                               r_busy, n_busy;
    logic                               r_done, n_done;
    logic                               r_neg, n_neg;
    logic [ssl_pkg::DIV_CNT_BITS-1:0]   r_cnt, n_cnt;
    logic [SB-1:0]                      r_q, n_q;
    logic [CB-1:0]                      r_rem, n_rem;
    logic [CB-1:0]                      r_div, n_div;
    logic [CB:0]                        s_rem_sh;
    logic                               s_fit;

    // remainder stays below the divisor, so CB bits hold it
    assign s_rem_sh = {r_rem, r_q[SB-1]};
    assign s_fit    = (s_rem_sh >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_neg  = r_neg;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_neg  = i_req.dividend[SB-1];
            n_q    = i_req.dividend[SB-1] ? SB'(-i_req.dividend) : SB'(i_req.dividend);
            n_rem  = '0;
            n_div  = i_req.divisor;
            n_cnt  = ssl_pkg::DIV_CNT_BITS'(SB);
        end else if (r_busy) begin
            n_q   = {r_q[SB-2:0], s_fit};
            n_rem = s_fit ? CB'(s_rem_sh - {1'b0, r_div}) : s_rem_sh[CB-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == ssl_pkg::DIV_CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_neg <= n_neg;
        r_cnt <= n_cnt;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

`default_nettype wire

// ===== sv/sensor_statistics_logger.sv =====
`default_nettype none

// Running max/min/average statistics over seven sensor channels. A word on the
// slave side carries the function in tuser: clear, sample (one channel per cycle
// through a shared compare/saturating-add unit) or report.
// A report emits seven words on the master side, one per channel, tlast on the
// seventh; each of channels 0-3 with a nonzero count runs the serial divider,
// the others skip it, and a master-side stall holds the report. The slave side
// is not ready while an item is in progress; one finished word may wait in the
// output register while the next item is accepted.
module sensor_statistics_logger (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // temperature[11:0], humidity[21:12], light[31:22], moisture[41:32],
    // color_code[43:42], accel_x[58:44], accel_y[73:59], accel_z[88:74], zero pad
    input  wire  [95:0] i_s_tdata,
    // func[1:0]
    input  wire  [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // maximum[14:0], minimum[29:15], average[44:30], average_valid[45],
    // majority_color[47:46], sample_total[63:48]
    output logic [63:0] o_m_tdata,
    // channel[2:0]
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast
);

    localparam int SB = ssl_pkg::SUM_BITS;
    localparam int CB = ssl_pkg::COUNT_BITS;
    localparam int VB = ssl_pkg::VAL_BITS;
    localparam int OB = ssl_pkg::OUT_BITS;
    localparam int VTB = ssl_pkg::VOTE_BITS;

    ssl_pkg::t_state                r_state, n_state;
    ssl_pkg::t_ctl                  s_ctl;
    ssl_pkg::t_div_req              s_div_req;
    ssl_pkg::t_div_rsp              s_div_rsp;

    ssl_pkg::t_sample               r_in;
    logic [ssl_pkg::CH_BITS-1:0]    r_idx;
    logic                           r_acc;

    logic signed [VB-1:0]           r_max [ssl_pkg::NUM_CH];
    logic signed [VB-1:0]           r_min [ssl_pkg::NUM_CH];
    logic signed [SB-1:0]           r_sum [ssl_pkg::NUM_SUM];
    logic [VTB-1:0]                 r_votes [3];
    logic [CB-1:0]                  r_count;

    logic                           r_out_valid;
    logic [ssl_pkg::M_TDATA_BITS-1:0] r_out_data;
    logic [ssl_pkg::CH_BITS-1:0]    r_out_ch;
    logic                           r_out_last;

    logic                           s_s_acc;
    logic                           s_out_free;
    logic                           s_is_sum_ch;
    logic                           s_avg_ok;
    logic signed [VB-1:0]           s_val;
    logic signed [SB:0]             s_sum_wide;
    logic signed [SB-1:0]           s_sum_sat;
    logic [1:0]                     s_dom;
    logic [ssl_pkg::TOTAL_BITS-1:0] s_total;
    logic signed [OB-1:0]           s_avg;

    assign s_s_acc     = i_s_tvalid && o_s_tready;
    assign s_out_free  = !r_out_valid || i_m_tready;
    assign s_is_sum_ch = (r_idx < ssl_pkg::CH_BITS'(ssl_pkg::NUM_SUM));
    assign s_avg_ok    = s_is_sum_ch && (r_count != '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ssl_pkg::ST_IDLE: begin
                if (s_s_acc) begin
                    case (ssl_pkg::t_func'(i_s_tuser))
                        ssl_pkg::FUNC_CLEAR:  n_state = ssl_pkg::ST_CLEAR;
                        ssl_pkg::FUNC_SAMPLE: n_state = ssl_pkg::ST_SAMPLE;
                        ssl_pkg::FUNC_REPORT: n_state = ssl_pkg::ST_REP_START;
                        default:              n_state = ssl_pkg::ST_IDLE;
                    endcase
                end
            end
            ssl_pkg::ST_CLEAR:  n_state = ssl_pkg::ST_IDLE;
            ssl_pkg::ST_SAMPLE: begin
                if (r_idx == ssl_pkg::LAST_CH) n_state = ssl_pkg::ST_IDLE;
            end
            ssl_pkg::ST_REP_START: begin
                n_state = s_avg_ok ? ssl_pkg::ST_REP_DIV : ssl_pkg::ST_REP_EMIT;
            end
            ssl_pkg::ST_REP_DIV: begin
                if (s_div_rsp.done) n_state = ssl_pkg::ST_REP_EMIT;
            end
            ssl_pkg::ST_REP_EMIT: begin
                if (s_out_free) begin
                    n_state = (r_idx == ssl_pkg::LAST_CH) ? ssl_pkg::ST_IDLE
                                                           : ssl_pkg::ST_REP_START;
                end
            end
            default: n_state = ssl_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ctl = '0;
        unique case (r_state)
            ssl_pkg::ST_IDLE:      s_ctl.s_ready   = 1'b1;
            ssl_pkg::ST_CLEAR:     s_ctl.clear     = 1'b1;
            ssl_pkg::ST_SAMPLE:    s_ctl.step      = 1'b1;
            ssl_pkg::ST_REP_START: s_ctl.div_start = s_avg_ok;
            ssl_pkg::ST_REP_DIV:   s_ctl = '0;
            ssl_pkg::ST_REP_EMIT:  s_ctl.emit      = s_out_free;
            default:               s_ctl = '0;
        endcase
    end

    assign o_s_tready = s_ctl.s_ready;

    // shared compare / saturating add unit
    assign s_val      = ssl_pkg::chan_val(r_in, r_idx);
    assign s_sum_wide = {r_sum[r_idx[1:0]][SB-1], r_sum[r_idx[1:0]]}
                      + {{(SB + 1 - VB){s_val[VB-1]}}, s_val};
    always_comb begin
        if (s_sum_wide[SB] != s_sum_wide[SB-1]) begin
            s_sum_sat = s_sum_wide[SB] ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}};
        end else begin
            s_sum_sat = s_sum_wide[SB-1:0];
        end
    end

    always_comb begin
        if (r_votes[0] > r_votes[1] && r_votes[0] > r_votes[2]) begin
            s_dom = ssl_pkg::COLOR_RED;
        end else if (r_votes[1] > r_votes[2] && r_votes[1] > r_votes[0]) begin
            s_dom = ssl_pkg::COLOR_GREEN;
        end else if (r_votes[2] > r_votes[0] && r_votes[2] > r_votes[1]) begin
            s_dom = ssl_pkg::COLOR_BLUE;
        end else begin
            s_dom = ssl_pkg::COLOR_NONE;
        end
    end

    assign s_total = (ssl_pkg::CMP_BITS'(r_count) > ssl_pkg::CMP_BITS'(16'hFFFF))
                   ? 16'hFFFF : ssl_pkg::TOTAL_BITS'(r_count);
    assign s_avg   = s_avg_ok ? s_div_rsp.quotient[OB-1:0] : '0;

    assign s_div_req.start    = s_ctl.div_start;
    assign s_div_req.dividend = r_sum[r_idx[1:0]];
    assign s_div_req.divisor  = r_count;

    ssl_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_div_req),
        .o_rsp   (s_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssl_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_acc       <= 1'b0;
            r_count     <= '0;
            for (int i = 0; i < ssl_pkg::NUM_CH; i++) begin
                r_max[i] <= ssl_pkg::low_sentinel(ssl_pkg::CH_BITS'(i));
                r_min[i] <= ssl_pkg::high_sentinel(ssl_pkg::CH_BITS'(i));
            end
            for (int i = 0; i < ssl_pkg::NUM_SUM; i++) r_sum[i] <= '0;
            for (int i = 0; i < 3; i++) r_votes[i] <= '0;
        end else begin
            r_state <= n_state;
            if (s_ctl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            if (s_s_acc) begin
                r_idx <= '0;
                r_acc <= (r_count != '1);
            end

            if (s_ctl.clear) begin
                r_count <= '0;
                for (int i = 0; i < ssl_pkg::NUM_CH; i++) begin
                    r_max[i] <= ssl_pkg::low_sentinel(ssl_pkg::CH_BITS'(i));
                    r_min[i] <= ssl_pkg::high_sentinel(ssl_pkg::CH_BITS'(i));
                end
                for (int i = 0; i < ssl_pkg::NUM_SUM; i++) r_sum[i] <= '0;
                for (int i = 0; i < 3; i++) r_votes[i] <= '0;
            end

            if (s_ctl.step) begin
                if (s_val > r_max[r_idx]) r_max[r_idx] <= s_val;
                if (s_val < r_min[r_idx]) r_min[r_idx] <= s_val;
                if (s_is_sum_ch && r_acc) r_sum[r_idx[1:0]] <= s_sum_sat;
                r_idx <= r_idx + 1'b1;
                // count and vote once, on the last channel
                if (r_idx == ssl_pkg::LAST_CH && r_acc) begin
                    r_count <= r_count + 1'b1;
                    if (r_in.color_code != ssl_pkg::COLOR_NONE
                        && r_votes[r_in.color_code - 2'd1] != '1) begin
                        r_votes[r_in.color_code - 2'd1] <= r_votes[r_in.color_code - 2'd1] + 1'b1;
                    end
                end
            end

            if (s_ctl.emit) r_idx <= r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_s_acc) r_in <= i_s_tdata[ssl_pkg::SAMPLE_BITS-1:0];
        if (s_ctl.emit) begin
            r_out_data <= {s_total, s_dom, s_avg_ok, s_avg,
                           r_min[r_idx][OB-1:0], r_max[r_idx][OB-1:0]};
            r_out_ch   <= r_idx;
            r_out_last <= (r_idx == ssl_pkg::LAST_CH);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_ch;
    assign o_m_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_last_on_final_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser == ssl_pkg::LAST_CH)))
        else $error("tlast does not match final channel");

    a_avg_valid_channels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[45]) |-> (o_m_tuser < 3'd4))
        else $error("average flagged valid on a channel without sum");

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[63:48] != 16'd0)
            |-> ($signed(o_m_tdata[29:15]) <= $signed(o_m_tdata[14:0])))
        else $error("minimum above maximum after samples");

    a_busy_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_s_acc && i_s_tuser == ssl_pkg::FUNC_REPORT) |=> !o_s_tready)
        else $error("ready right after accepting a report");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
module testbench;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int NUM_ITEMS   = 430;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 800;
    localparam int DRAIN       = 200;
    localparam longint SUM_MAX = (longint'(1) << (ssl_pkg::SUM_BITS - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    typedef struct {
        logic [1:0]       func;
        ssl_pkg::t_sample word;
    } t_item;

    typedef struct {
        logic [2:0]  channel;
        logic [14:0] maximum;
        logic [14:0] minimum;
        logic [14:0] average;
        logic        avg_ok;
        logic [1:0]  color;
        logic [15:0] total;
        logic        last;
    } t_stat_word;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = ssl_pkg::FUNC_CLEAR;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [63:0] m_tdata;
    wire  [2:0]  m_tuser;
    wire         m_tlast;

    sensor_statistics_logger uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    always #2 i_clk = ~i_clk;

    t_item      pending_q[$];
    t_stat_word report_q[$];
    t_item      cur_item;
    logic       s_taken = 1'b0;
    int         error_count = 0;
    int         words_seen = 0;
    int         idle_cycles = 0;

    // running statistics as the block should hold them
    logic signed [15:0]             ch_max[ssl_pkg::NUM_CH];
    logic signed [15:0]             ch_min[ssl_pkg::NUM_CH];
    longint                         ch_sum[ssl_pkg::NUM_SUM];
    logic [ssl_pkg::VOTE_BITS-1:0]  votes[3];
    logic [ssl_pkg::COUNT_BITS-1:0] n_samples;

    task automatic clear_stats();
        for (int i = 0; i < ssl_pkg::NUM_CH; i++) begin
            case (i)
                0:       begin ch_max[i] = -16'sd600;  ch_min[i] = 16'sd2000; end
                1, 2, 3: begin ch_max[i] = 16'sd0;     ch_min[i] = 16'sd1000; end
                default: begin ch_max[i] = -16'sd9900; ch_min[i] = 16'sd9900; end
            endcase
        end
        for (int i = 0; i < ssl_pkg::NUM_SUM; i++) ch_sum[i] = 0;
        for (int i = 0; i < 3; i++) votes[i] = '0;
        n_samples = '0;
    endtask

    function automatic logic [1:0] majority_color();
        logic [1:0] c;
        c = ssl_pkg::COLOR_NONE;
        if (votes[0] > votes[1] && votes[0] > votes[2])
            c = ssl_pkg::COLOR_RED;
        else if (votes[1] > votes[0] && votes[1] > votes[2])
            c = ssl_pkg::COLOR_GREEN;
        else if (votes[2] > votes[0] && votes[2] > votes[1])
            c = ssl_pkg::COLOR_BLUE;
        return c;
    endfunction

    task automatic update_stats(input t_item it);
        logic signed [15:0] vals[ssl_pkg::NUM_CH];
        longint             v;
        t_stat_word         w;
        if (it.func == ssl_pkg::FUNC_CLEAR) begin
            clear_stats();
        end else if (it.func == ssl_pkg::FUNC_SAMPLE) begin
            vals[0] = {{4{it.word.temperature[11]}}, it.word.temperature};
            vals[1] = {6'd0, it.word.humidity};
            vals[2] = {6'd0, it.word.light};
            vals[3] = {6'd0, it.word.moisture};
            vals[4] = {it.word.accel_x[14], it.word.accel_x};
            vals[5] = {it.word.accel_y[14], it.word.accel_y};
            vals[6] = {it.word.accel_z[14], it.word.accel_z};
            for (int i = 0; i < ssl_pkg::NUM_CH; i++) begin
                if (vals[i] > ch_max[i]) ch_max[i] = vals[i];
                if (vals[i] < ch_min[i]) ch_min[i] = vals[i];
            end
            // sums, votes and count freeze once the count saturates
            if (n_samples != {ssl_pkg::COUNT_BITS{1'b1}}) begin
                for (int i = 0; i < ssl_pkg::NUM_SUM; i++) begin
                    v = longint'(vals[i]);
                    if (v > 0 && ch_sum[i] > SUM_MAX - v)
                        ch_sum[i] = SUM_MAX;
                    else if (v < 0 && ch_sum[i] < SUM_MIN - v)
                        ch_sum[i] = SUM_MIN;
                    else
                        ch_sum[i] = ch_sum[i] + v;
                end
                n_samples++;
                case (it.word.color_code)
                    ssl_pkg::COLOR_RED:
                        if (votes[0] != {ssl_pkg::VOTE_BITS{1'b1}}) votes[0]++;
                    ssl_pkg::COLOR_GREEN:
                        if (votes[1] != {ssl_pkg::VOTE_BITS{1'b1}}) votes[1]++;
                    ssl_pkg::COLOR_BLUE:
                        if (votes[2] != {ssl_pkg::VOTE_BITS{1'b1}}) votes[2]++;
                    default: ;
                endcase
            end
        end else if (it.func == ssl_pkg::FUNC_REPORT) begin
            for (int i = 0; i < ssl_pkg::NUM_CH; i++) begin
                w.channel = i[2:0];
                w.maximum = ch_max[i][14:0];
                w.minimum = ch_min[i][14:0];
                w.average = '0;
                w.avg_ok  = 1'b0;
                if (i < ssl_pkg::NUM_SUM && n_samples != 0) begin
                    v = ch_sum[i] / longint'(n_samples);
                    w.average = v[14:0];
                    w.avg_ok  = 1'b1;
                end
                w.color = majority_color();
                w.total = ssl_pkg::TOTAL_BITS'(n_samples);
                w.last  = (i == ssl_pkg::NUM_CH - 1);
                report_q.push_back(w);
            end
        end
    endtask

    function automatic ssl_pkg::t_sample make_sample(input int temp, input int hum,
                                                     input int lt, input int moist,
                                                     input int col, input int ax,
                                                     input int ay, input int az);
        ssl_pkg::t_sample s;
        s.temperature = 12'(temp);
        s.humidity    = 10'(hum);
        s.light       = 10'(lt);
        s.moisture    = 10'(moist);
        s.color_code  = 2'(col);
        s.accel_x     = 15'(ax);
        s.accel_y     = 15'(ay);
        s.accel_z     = 15'(az);
        return s;
    endfunction

    // mostly in the physical range, now and then any bit pattern
    function automatic int pick(input int lo, input int hi, input int bits);
        if ($urandom_range(0, 7) == 0)
            return int'($urandom_range(0, (1 << bits) - 1));
        return int'($urandom_range(0, hi - lo)) + lo;
    endfunction

    function automatic ssl_pkg::t_sample rand_sample(input logic [1:0] favored);
        int col;
        col = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 3)) : int'(favored);
        return make_sample(pick(-600, 2000, 12), pick(0, 1000, 10), pick(0, 1000, 10),
                           pick(0, 1000, 10), col, pick(-9900, 9900, 15),
                           pick(-9900, 9900, 15), pick(-9900, 9900, 15));
    endfunction

    task automatic push_item(input logic [1:0] func, input ssl_pkg::t_sample s);
        t_item it;
        it.func = func;
        it.word = s;
        pending_q.push_back(it);
    endtask

    // sender: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin
        if (rst_n && (s_taken || !s_tvalid)) begin
            s_taken = 1'b0;
            if (burst_left == 0) begin
                burst_left = int'($urandom_range(1, 24));
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 10));
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur_item = pending_q.pop_front();
                s_tdata  <= ssl_pkg::S_TDATA_BITS'(cur_item.word);
                s_tuser  <= cur_item.func;
                s_tvalid <= 1'b1;
                burst_left--;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall modes of random length, plus one long hold-off
    int  rx_mode = 0;
    int  mode_left = 0;
    int  hold_left = 0;
    logic hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && words_seen >= 40) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = int'($urandom_range(0, 3));
                mode_left = int'($urandom_range(10, 150));
            end
            mode_left--;
            case (rx_mode)
                2:       m_tready <= 1'($urandom_range(0, 1));
                3:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // monitor and predictor
    t_stat_word got, want;

    always @(posedge i_clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                s_taken = 1'b1;
                update_stats(cur_item);
            end
            if (m_tvalid && m_tready) begin
                words_seen++;
                got.maximum = m_tdata[14:0];
                got.minimum = m_tdata[29:15];
                got.average = m_tdata[44:30];
                got.avg_ok  = m_tdata[45];
                got.color   = m_tdata[47:46];
                got.total   = m_tdata[63:48];
                got.channel = m_tuser;
                got.last    = m_tlast;
                if (report_q.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected word: ch %0d max %0d min %0d", got.channel,
                                 $signed(got.maximum), $signed(got.minimum));
                end else begin
                    want = report_q.pop_front();
                    if (got.channel !== want.channel || got.maximum !== want.maximum ||
                        got.minimum !== want.minimum || got.average !== want.average ||
                        got.avg_ok !== want.avg_ok || got.color !== want.color ||
                        got.total !== want.total || got.last !== want.last) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $write("mismatch exp: ch %0d max %0d min %0d avg %0d",
                                   want.channel, $signed(want.maximum),
                                   $signed(want.minimum), $signed(want.average));
                            $display(" ok %0b col %0d n %0d last %0b",
                                     want.avg_ok, want.color, want.total, want.last);
                            $write("         got: ch %0d max %0d min %0d avg %0d",
                                   got.channel, $signed(got.maximum),
                                   $signed(got.minimum), $signed(got.average));
                            $display(" ok %0b col %0d n %0d last %0b",
                                     got.avg_ok, got.color, got.total, got.last);
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin
        wait (rst_n);
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int         counted;
        logic [1:0] favored;
        int         r;
        clear_stats();

        // directed: empty report, extremes, ties, majority, truncation of negative averages
        push_item(ssl_pkg::FUNC_REPORT, rand_sample(ssl_pkg::COLOR_RED));
        push_item(FUNC_UNUSED, rand_sample(ssl_pkg::COLOR_RED));
        push_item(ssl_pkg::FUNC_SAMPLE, make_sample(2047, 1023, 1023, 1023, ssl_pkg::COLOR_RED,
                                                    16383, 16383, 16383));
        push_item(ssl_pkg::FUNC_SAMPLE, make_sample(-2048, 0, 0, 0, ssl_pkg::COLOR_NONE,
                                                    -16384, -16384, -16384));
        push_item(ssl_pkg::FUNC_SAMPLE, make_sample(-600, 1000, 500, 1, ssl_pkg::COLOR_GREEN,
                                                    -9900, 9900, 0));
        push_item(ssl_pkg::FUNC_REPORT, rand_sample(ssl_pkg::COLOR_NONE));
        push_item(ssl_pkg::FUNC_SAMPLE, make_sample(2000, 999, 0, 1000, ssl_pkg::COLOR_BLUE,
                                                    9900, -9900, 1));
        push_item(ssl_pkg::FUNC_SAMPLE, make_sample(0, 0, 1000, 0, ssl_pkg::COLOR_BLUE,
                                                    0, 0, -1));
        push_item(ssl_pkg::FUNC_REPORT, rand_sample(ssl_pkg::COLOR_NONE));
        push_item(ssl_pkg::FUNC_CLEAR, rand_sample(ssl_pkg::COLOR_GREEN));
        push_item(ssl_pkg::FUNC_REPORT, rand_sample(ssl_pkg::COLOR_GREEN));
        push_item(ssl_pkg::FUNC_SAMPLE, make_sample(-5, 3, 7, 1, ssl_pkg::COLOR_GREEN,
                                                    -1, 1, 0));
        push_item(ssl_pkg::FUNC_SAMPLE, make_sample(-2, 0, 0, 0, ssl_pkg::COLOR_GREEN,
                                                    1, -1, 0));
        push_item(ssl_pkg::FUNC_SAMPLE, make_sample(-1, 1, 1, 1, ssl_pkg::COLOR_RED,
                                                    0, 0, 0));
        push_item(ssl_pkg::FUNC_REPORT, rand_sample(ssl_pkg::COLOR_BLUE));
        push_item(FUNC_UNUSED, rand_sample(ssl_pkg::COLOR_BLUE));
        push_item(ssl_pkg::FUNC_CLEAR, rand_sample(ssl_pkg::COLOR_BLUE));
        push_item(ssl_pkg::FUNC_SAMPLE, make_sample(1, 1, 1, 1, ssl_pkg::COLOR_NONE,
                                                    1, 1, 1));
        push_item(ssl_pkg::FUNC_REPORT, rand_sample(ssl_pkg::COLOR_RED));
        counted = 17;

        favored = ssl_pkg::COLOR_RED;
        while (counted < NUM_ITEMS) begin
            r = int'($urandom_range(0, 99));
            if (r < 3) begin
                push_item(ssl_pkg::FUNC_CLEAR, rand_sample(favored));
                favored = 2'($urandom_range(0, 3));
                counted++;
            end else if (r < 6) begin
                push_item(FUNC_UNUSED, rand_sample(favored));
            end else if (r < 20) begin
                push_item(ssl_pkg::FUNC_REPORT, rand_sample(favored));
                counted++;
            end else begin
                push_item(ssl_pkg::FUNC_SAMPLE, rand_sample(favored));
                counted++;
            end
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid) @(posedge i_clk);
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (report_q.size() != 0) error_count++;
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
